// ===== rtl/core/imss_pkg.sv =====
// shared types and constants for the imu sample scale and smooth block
package imss_pkg;

  localparam int WORD_W    = 16;
  localparam int ID_W      = 8;
  localparam int OUT_W     = 23;
  localparam int STATE_W   = 32;
  localparam int WEIGHT_W  = 17;
  localparam int W_FRAC    = 16;
  localparam int NUM_AXES  = 6;
  localparam int AXIS_W    = 3;
  localparam int GYRO_BASE = 3;
  localparam int CFG_AW    = 2;
  localparam int CFG_DW    = 32;

  localparam logic [ID_W-1:0]     GYRO_ID_OK   = 8'h0F;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 17'd65536;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'd19661;

  localparam logic [CFG_AW-1:0] ADDR_SMOOTHING_WEIGHT = 2'd0;

  // accel: 147 / (5 * 2^14) per count
  localparam longint unsigned ACC_MUL       = 147;
  localparam longint unsigned ACC_ODD       = 5;
  localparam int              ACC_DEN_SHIFT = 14;
  // gyro: 436332313 / (390625 * 2^20) per count
  localparam longint unsigned RATE_MUL       = 436332313;
  localparam longint unsigned RATE_ODD       = 390625;
  localparam int              RATE_DEN_SHIFT = 20;

  typedef logic [WORD_W-1:0]          word_t;
  typedef logic [WEIGHT_W-1:0]        weight_t;
  typedef logic signed [OUT_W-1:0]    out_val_t;
  typedef logic signed [STATE_W-1:0]  state_val_t;

  typedef struct packed {
    logic       start;
    logic       is_rate;
    logic       seeded;
    word_t      count;
    state_val_t prev;
    weight_t    weight;
  } eng_req_t;

  typedef struct packed {
    logic       done;
    state_val_t scaled;
    state_val_t smoothed;
  } eng_rsp_t;

endpackage

// ===== rtl/core/imss_in_if.sv =====
// sample channel: raw accel and gyro words plus gyro identity byte
interface imss_in_if;
  import imss_pkg::*;

  logic             valid;
  logic             ready;
  word_t            accel_x_word;
  word_t            accel_y_word;
  word_t            accel_z_word;
  logic [ID_W-1:0]  gyro_id_byte;
  word_t            gyro_x_word;
  word_t            gyro_y_word;
  word_t            gyro_z_word;

  modport source (
    output valid, accel_x_word, accel_y_word, accel_z_word, gyro_id_byte,
           gyro_x_word, gyro_y_word, gyro_z_word,
    input  ready
  );

  modport sink (
    input  valid, accel_x_word, accel_y_word, accel_z_word, gyro_id_byte,
           gyro_x_word, gyro_y_word, gyro_z_word,
    output ready
  );
endinterface

// ===== rtl/core/imss_out_if.sv =====
// result channel: scaled and smoothed accel and rate values
interface imss_out_if;
  import imss_pkg::*;

  logic     valid;
  logic     ready;
  out_val_t accel_x_scaled;
  out_val_t accel_y_scaled;
  out_val_t accel_z_scaled;
  out_val_t rate_x_scaled;
  out_val_t rate_y_scaled;
  out_val_t rate_z_scaled;
  out_val_t accel_x_smoothed;
  out_val_t accel_y_smoothed;
  out_val_t accel_z_smoothed;
  out_val_t rate_x_smoothed;
  out_val_t rate_y_smoothed;
  out_val_t rate_z_smoothed;

  modport source (
    output valid, accel_x_scaled, accel_y_scaled, accel_z_scaled,
           rate_x_scaled, rate_y_scaled, rate_z_scaled,
           accel_x_smoothed, accel_y_smoothed, accel_z_smoothed,
           rate_x_smoothed, rate_y_smoothed, rate_z_smoothed,
    input  ready
  );

  modport sink (
    input  valid, accel_x_scaled, accel_y_scaled, accel_z_scaled,
           rate_x_scaled, rate_y_scaled, rate_z_scaled,
           accel_x_smoothed, accel_y_smoothed, accel_z_smoothed,
           rate_x_smoothed, rate_y_smoothed, rate_z_smoothed,
    output ready
  );
endinterface

// ===== rtl/core/imss_scale_engine.sv =====
// bit-serial scale and smoothing engine shared by all six axes
module imss_scale_engine #(
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  imss_pkg::eng_req_t req,
  output imss_pkg::eng_rsp_t rsp
);
  import imss_pkg::*;

  localparam int A_LSH = (FRACTION_BITS >= ACC_DEN_SHIFT) ? FRACTION_BITS - ACC_DEN_SHIFT : 0;
  localparam int A_RSH = (FRACTION_BITS >= ACC_DEN_SHIFT) ? 0 : ACC_DEN_SHIFT - FRACTION_BITS;
  localparam int R_LSH = (FRACTION_BITS >= RATE_DEN_SHIFT) ? FRACTION_BITS - RATE_DEN_SHIFT : 0;
  localparam int R_RSH = (FRACTION_BITS >= RATE_DEN_SHIFT) ? 0 : RATE_DEN_SHIFT - FRACTION_BITS;

  localparam longint unsigned A_MULK = ACC_MUL << A_LSH;
  localparam longint unsigned R_MULK = RATE_MUL << R_LSH;
  localparam longint unsigned A_HALF = (ACC_ODD << A_RSH) >> 1;
  localparam longint unsigned R_HALF = (RATE_ODD << R_RSH) >> 1;

  localparam int MKW = $clog2(R_MULK + 1);
  localparam int PW  = MKW + WORD_W + 1;
  localparam int SAW = STATE_W + WEIGHT_W + 1;
  localparam int AW  = (PW > SAW) ? PW : SAW;
  localparam int QW  = FRACTION_BITS + 6;
  localparam int RW  = $clog2(RATE_ODD) + 1;
  localparam int SHW = $clog2(RATE_DEN_SHIFT + 1);
  localparam int CW  = $clog2(((QW > WEIGHT_W) ? QW : WEIGHT_W) + 1);

  localparam logic [AW-1:0] RND_POS = AW'(1) << (W_FRAC - 1);
  localparam logic [AW-1:0] RND_NEG = RND_POS - AW'(1);

  localparam logic [2:0] E_IDLE = 3'd0;
  localparam logic [2:0] E_MUL  = 3'd1;
  localparam logic [2:0] E_DIVP = 3'd2;
  localparam logic [2:0] E_DIV  = 3'd3;
  localparam logic [2:0] E_SGN  = 3'd4;
  localparam logic [2:0] E_DIFF = 3'd5;
  localparam logic [2:0] E_RND  = 3'd6;

  logic [2:0]         st_r;
  logic [AW-1:0]      acc_r;
  logic [AW-1:0]      add_r;
  logic [WEIGHT_W-1:0] mb_r;
  logic [CW-1:0]      cnt_r;
  logic               ph_r;
  logic [SHW-1:0]     rsh_r;
  logic               is_rate_r;
  logic               neg_r;
  logic               seeded_r;
  state_val_t         prev_r;
  weight_t            w_r;
  logic [RW-1:0]      rem_r;
  logic [QW-1:0]      quo_r;
  state_val_t         scl_r;
  state_val_t         smo_r;
  logic               done_r;

  word_t              mag;
  logic [AW-1:0]      num;
  logic [RW-1:0]      odd;
  logic [RW-1:0]      rem2;
  logic               ge;
  logic [STATE_W-1:0] q32;
  logic [STATE_W-1:0] scl_val;
  logic [STATE_W:0]   diff;
  logic [AW-1:0]      rnd_sum;

  always_comb begin
    mag     = req.count[WORD_W-1] ? WORD_W'(~req.count + 1'b1) : req.count;
    num     = acc_r >> rsh_r;
    odd     = is_rate_r ? RW'(RATE_ODD) : RW'(ACC_ODD);
    rem2    = {rem_r[RW-2:0], quo_r[QW-1]};
    ge      = (rem2 >= odd);
    q32     = {{(STATE_W-QW){1'b0}}, quo_r};
    scl_val = neg_r ? (~q32 + 1'b1) : q32;
    diff    = {scl_r[STATE_W-1], scl_r} - {prev_r[STATE_W-1], prev_r};
    // ties away from zero: bias one less on the negative side
    rnd_sum = acc_r + (acc_r[AW-1] ? RND_NEG : RND_POS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= E_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        E_IDLE: begin
          if (req.start) begin
            acc_r     <= req.is_rate ? AW'(R_HALF) : AW'(A_HALF);
            add_r     <= req.is_rate ? AW'(R_MULK) : AW'(A_MULK);
            mb_r      <= WEIGHT_W'(mag);
            rsh_r     <= req.is_rate ? SHW'(R_RSH) : SHW'(A_RSH);
            is_rate_r <= req.is_rate;
            neg_r     <= req.count[WORD_W-1];
            seeded_r  <= req.seeded;
            prev_r    <= req.prev;
            w_r       <= req.weight;
            ph_r      <= 1'b0;
            cnt_r     <= '0;
            st_r      <= E_MUL;
          end
        end
        E_MUL: begin
          // one multiplier bit per cycle
          if (mb_r[0]) begin
            acc_r <= acc_r + add_r;
          end
          add_r <= add_r << 1;
          mb_r  <= mb_r >> 1;
          if (cnt_r == CW'(WEIGHT_W - 1)) begin
            cnt_r <= '0;
            st_r  <= ph_r ? E_RND : E_DIVP;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        E_DIVP: begin
          rem_r <= RW'(num >> QW);
          quo_r <= num[QW-1:0];
          cnt_r <= '0;
          st_r  <= E_DIV;
        end
        E_DIV: begin
          // restoring division, one quotient bit per cycle
          rem_r <= ge ? (rem2 - odd) : rem2;
          quo_r <= {quo_r[QW-2:0], ge};
          if (cnt_r == CW'(QW - 1)) begin
            cnt_r <= '0;
            st_r  <= E_SGN;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        E_SGN: begin
          scl_r <= scl_val;
          if (!seeded_r) begin
            smo_r  <= scl_val;
            done_r <= 1'b1;
            st_r   <= E_IDLE;
          end else begin
            st_r <= E_DIFF;
          end
        end
        E_DIFF: begin
          // prev * 2^16 + w * (x - prev)
          acc_r <= {{(AW-STATE_W-W_FRAC){prev_r[STATE_W-1]}}, prev_r, {W_FRAC{1'b0}}};
          add_r <= {{(AW-STATE_W-1){diff[STATE_W]}}, diff};
          mb_r  <= w_r;
          ph_r  <= 1'b1;
          cnt_r <= '0;
          st_r  <= E_MUL;
        end
        E_RND: begin
          smo_r  <= rnd_sum[W_FRAC +: STATE_W];
          done_r <= 1'b1;
          st_r   <= E_IDLE;
        end
        default: begin
          st_r <= E_IDLE;
        end
      endcase
    end
  end

  assign rsp.done     = done_r;
  assign rsp.scaled   = scl_r;
  assign rsp.smoothed = smo_r;

endmodule

// ===== rtl/core/imu_sample_scale_and_smooth.sv =====
// top level: imu sample scaling to fixed point and exponential smoothing
//
// usage
//   in_ch carries one six-axis read per transfer: three accel words, three
//   gyro words and the gyro identity byte. gyro words are taken only when the
//   identity byte is 0x0F, otherwise the last taken gyro words are reused.
//   out_ch carries one result per input transfer: six scaled values and six
//   smoothed values, signed with FRACTION_BITS fraction bits, low 23 bits.
//   the apb port holds the smoothing weight (byte address 0); the user must
//   write it only while no sample is in flight, the block does not enforce it.
// engine
//   one shared bit-serial engine handles the six axes in turn; per axis it
//   runs the scale multiply, then the divide, then the filter multiply; the
//   very first sample skips the filter multiply.
// reset and stall
//   after reset the weight is 19661, the held gyro words are zero and the
//   filter is unseeded, so the first sample loads the filter state directly.
//   a finished result sits in the output register; the next sample is
//   accepted and worked on while it waits, but is only handed over once the
//   receiver has taken the previous transfer.
module imu_sample_scale_and_smooth #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  imss_in_if.sink                        in_ch,
  imss_out_if.source                     out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [imss_pkg::CFG_AW-1:0]    paddr,
  input  logic [imss_pkg::CFG_DW-1:0]    pwdata,
  output logic [imss_pkg::CFG_DW-1:0]    prdata,
  output logic                           pready
);
  import imss_pkg::*;

  // sequencer states
  localparam logic [1:0] T_IDLE  = 2'd0;
  localparam logic [1:0] T_ISSUE = 2'd1;
  localparam logic [1:0] T_WAIT  = 2'd2;
  localparam logic [1:0] T_OUT   = 2'd3;

  logic [1:0]        st_r;
  logic [AXIS_W-1:0] axis_r;
  logic              seeded_r;
  weight_t           weight_r;
  logic              out_valid_r;

  // raw words: accel entries per sample, gyro entries are the held counts
  word_t      wd_r [NUM_AXES];
  // filter state per axis
  state_val_t sm_r [NUM_AXES];
  // scaled values of the sample being worked on
  out_val_t   scw_r [NUM_AXES];
  // output register
  out_val_t   out_scl_r [NUM_AXES];
  out_val_t   out_smo_r [NUM_AXES];

  weight_t    w_eff;
  logic       in_xfer;
  logic       out_xfer;
  logic       out_load;
  logic       cfg_wr;
  eng_req_t   req;
  eng_rsp_t   rsp;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_xfer = out_valid_r && out_ch.ready;
  assign out_load = (st_r == T_OUT) && (!out_valid_r || out_ch.ready);
  assign cfg_wr   = psel && penable && pwrite && (paddr == ADDR_SMOOTHING_WEIGHT);

  // weights above one mean no smoothing
  assign w_eff = (weight_r > WEIGHT_ONE) ? WEIGHT_ONE : weight_r;

  assign in_ch.ready = (st_r == T_IDLE);

  always_comb begin
    req.start   = (st_r == T_ISSUE);
    req.is_rate = (axis_r >= AXIS_W'(GYRO_BASE));
    req.seeded  = seeded_r;
    req.count   = wd_r[axis_r];
    req.prev    = sm_r[axis_r];
    req.weight  = w_eff;
  end

  imss_scale_engine #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= WEIGHT_RESET;
    end else if (cfg_wr) begin
      weight_r <= pwdata[WEIGHT_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_SMOOTHING_WEIGHT) ? CFG_DW'(weight_r) : '0;

  // sequencer: capture sample, walk the six axes, hand over the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= T_IDLE;
      axis_r   <= '0;
      seeded_r <= 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
        wd_r[i] <= '0;
        sm_r[i] <= '0;
      end
    end else begin
      unique case (st_r)
        T_IDLE: begin
          if (in_xfer) begin
            wd_r[0] <= in_ch.accel_x_word;
            wd_r[1] <= in_ch.accel_y_word;
            wd_r[2] <= in_ch.accel_z_word;
            // gyro words only with a good identity byte
            if (in_ch.gyro_id_byte == GYRO_ID_OK) begin
              wd_r[GYRO_BASE]     <= in_ch.gyro_x_word;
              wd_r[GYRO_BASE + 1] <= in_ch.gyro_y_word;
              wd_r[GYRO_BASE + 2] <= in_ch.gyro_z_word;
            end
            axis_r <= '0;
            st_r   <= T_ISSUE;
          end
        end
        T_ISSUE: begin
          st_r <= T_WAIT;
        end
        T_WAIT: begin
          if (rsp.done) begin
            sm_r[axis_r] <= rsp.smoothed;
            if (axis_r == AXIS_W'(NUM_AXES - 1)) begin
              st_r <= T_OUT;
            end else begin
              axis_r <= axis_r + 1'b1;
              st_r   <= T_ISSUE;
            end
          end
        end
        T_OUT: begin
          if (out_load) begin
            seeded_r <= 1'b1;
            st_r     <= T_IDLE;
          end
        end
        default: begin
          st_r <= T_IDLE;
        end
      endcase
    end
  end

  // scaled value capture, no reset needed
  always_ff @(posedge clk) begin
    if (st_r == T_WAIT && rsp.done) begin
      scw_r[axis_r] <= rsp.scaled[OUT_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_xfer) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        out_scl_r[i] <= scw_r[i];
        out_smo_r[i] <= sm_r[i][OUT_W-1:0];
      end
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.accel_x_scaled   = out_scl_r[0];
  assign out_ch.accel_y_scaled   = out_scl_r[1];
  assign out_ch.accel_z_scaled   = out_scl_r[2];
  assign out_ch.rate_x_scaled    = out_scl_r[GYRO_BASE];
  assign out_ch.rate_y_scaled    = out_scl_r[GYRO_BASE + 1];
  assign out_ch.rate_z_scaled    = out_scl_r[GYRO_BASE + 2];
  assign out_ch.accel_x_smoothed = out_smo_r[0];
  assign out_ch.accel_y_smoothed = out_smo_r[1];
  assign out_ch.accel_z_smoothed = out_smo_r[2];
  assign out_ch.rate_x_smoothed  = out_smo_r[GYRO_BASE];
  assign out_ch.rate_y_smoothed  = out_smo_r[GYRO_BASE + 1];
  assign out_ch.rate_z_smoothed  = out_smo_r[GYRO_BASE + 2];

  // engine only finishes while the sequencer waits on it
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> st_r == T_WAIT)
    else $error("engine finished outside the wait state");

  // an accepted sample always starts at the first axis
  a_accept_first_axis: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (st_r == T_ISSUE) && (axis_r == '0))
    else $error("sample transfer did not start the axis walk");

  // any presented result implies the filter has been seeded
  a_out_seeded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> seeded_r)
    else $error("result presented with unseeded filter");

  // output valid only rises from the hand-over state
  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r) == T_OUT)
    else $error("output valid rose outside the hand-over state");

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench: random and directed imu reads against a scale and smoothing predictor
module testbench;
  import imss_pkg::*;

  localparam int FRAC_BITS     = 16;
  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 12;
  localparam int SEGMENTS      = 12;
  localparam int SEG_READS     = 130;
  localparam int HOLD_CYCLES   = 3000;
  localparam int QUIET_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 400;
  localparam int NUM_FIELDS    = 12;

  // accel count to m/s^2: 147 / (5 * 2^14), times 2^16 fraction bits
  localparam longint ACCEL_NUM = 588;
  localparam longint ACCEL_DEN = 5;
  // gyro count to rad/s: 436332313 / (390625 * 2^20), times 2^16 fraction bits
  localparam longint RATE_NUM  = 436332313;
  localparam longint RATE_DEN  = 6250000;
  localparam longint UNITY     = 65536;

  // byte address that holds no register
  localparam logic [CFG_AW-1:0] ADDR_SPARE = 2'd3;

  typedef struct packed {
    word_t [2:0]     accel;
    logic [ID_W-1:0] id;
    word_t [2:0]     gyro;
  } imu_read_t;

  // field order: accel scaled, rate scaled, accel smoothed, rate smoothed (x, y, z each)
  typedef struct {
    out_val_t vals[NUM_FIELDS];
  } imu_outputs_t;

  logic                clk;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CFG_AW-1:0]   paddr;
  logic [CFG_DW-1:0]   pwdata;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;

  imss_in_if  in_bus ();
  imss_out_if out_bus ();

  imu_sample_scale_and_smooth #(
    .FRACTION_BITS(FRAC_BITS)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_bus),
    .out_ch  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // reads waiting to be driven, and outputs the predictor says are due
  imu_read_t    pending_readings[$];
  imu_outputs_t awaited_outputs[$];

  // predictor copy of the block state
  weight_t filt_weight;
  logic    filt_seeded;
  word_t   held_gyro[3];
  int      filt_state[6];

  int   sender_idle_pct;
  int   receiver_idle_pct;
  int   holds_asked;
  int   holds_served;
  int   hold_left;
  logic in_taken;
  int   quiet_cycles;
  int   mismatch_count;

  string field_name[NUM_FIELDS] = '{
    "accel_x_scaled", "accel_y_scaled", "accel_z_scaled",
    "rate_x_scaled", "rate_y_scaled", "rate_z_scaled",
    "accel_x_smoothed", "accel_y_smoothed", "accel_z_smoothed",
    "rate_x_smoothed", "rate_y_smoothed", "rate_z_smoothed"
  };

  // divide rounding to nearest, ties away from zero
  function automatic longint round_div(input longint num, input longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q   = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint word_to_count(input word_t w);
    return longint'($signed(w));
  endfunction

  // one read in, one set of twelve outputs out; updates held gyro and filter state
  function automatic imu_outputs_t scale_and_smooth(input imu_read_t rd);
    imu_outputs_t res;
    longint       scaled_v;
    longint       w;
    int           k;
    if (rd.id == GYRO_ID_OK) begin
      for (k = 0; k < 3; k++) held_gyro[k] = rd.gyro[k];
    end
    // weights above one mean no smoothing
    w = (filt_weight > WEIGHT_ONE) ? UNITY : longint'(filt_weight);
    for (k = 0; k < 6; k++) begin
      if (k < 3) begin
        scaled_v = round_div(word_to_count(rd.accel[k]) * ACCEL_NUM, ACCEL_DEN);
      end else begin
        scaled_v = round_div(word_to_count(held_gyro[k-3]) * RATE_NUM, RATE_DEN);
      end
      // first read seeds the filter directly
      if (!filt_seeded) begin
        filt_state[k] = int'(scaled_v);
      end else begin
        filt_state[k] = int'(round_div(w * scaled_v + (UNITY - w) * filt_state[k], UNITY));
      end
      res.vals[k]     = scaled_v[OUT_W-1:0];
      res.vals[6 + k] = filt_state[k][OUT_W-1:0];
    end
    filt_seeded = 1'b1;
    return res;
  endfunction

  task automatic add_reading(input word_t ax, input word_t ay, input word_t az,
                             input logic [ID_W-1:0] id,
                             input word_t gx, input word_t gy, input word_t gz);
    imu_read_t rd;
    rd.accel[0] = ax;
    rd.accel[1] = ay;
    rd.accel[2] = az;
    rd.id       = id;
    rd.gyro[0]  = gx;
    rd.gyro[1]  = gy;
    rd.gyro[2]  = gz;
    pending_readings.push_back(rd);
  endtask

  // words biased toward the signed extremes and small values around zero
  function automatic word_t random_word();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'h7FFF;
      2: return 16'h8000;
      3: return 16'hFFFF;
      4: return word_t'($urandom_range(31) - 16);
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic logic [ID_W-1:0] random_id();
    case ($urandom_range(9))
      0, 1: return ID_W'($urandom);
      // one bit off the good identity
      2: return GYRO_ID_OK ^ (8'h01 << $urandom_range(7));
      default: return GYRO_ID_OK;
    endcase
  endfunction

  // apb write: setup cycle then access cycle, register written at the access edge
  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    if (addr == ADDR_SMOOTHING_WEIGHT) filt_weight = data[WEIGHT_W-1:0];
  endtask

  // sender quiet until every read is taken and every output has come back
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_readings.size() != 0 || in_bus.valid || awaited_outputs.size() != 0);
  endtask

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // driver: new read presented at the falling edge once the previous one is taken
  always @(negedge clk) begin : read_driver
    imu_read_t nxt;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_taken) begin
      if (pending_readings.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        nxt = pending_readings.pop_front();
        in_bus.accel_x_word <= nxt.accel[0];
        in_bus.accel_y_word <= nxt.accel[1];
        in_bus.accel_z_word <= nxt.accel[2];
        in_bus.gyro_id_byte <= nxt.id;
        in_bus.gyro_x_word  <= nxt.gyro[0];
        in_bus.gyro_y_word  <= nxt.gyro[1];
        in_bus.gyro_z_word  <= nxt.gyro[2];
        in_bus.valid        <= 1'b1;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // receiver: random back-pressure, plus long hold-offs on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_bus.ready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      out_bus.ready <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      holds_served  <= holds_asked;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // monitor: check each output transfer, predict on each input transfer, watchdog
  always @(posedge clk) begin : monitor
    imu_outputs_t want;
    out_val_t     got[NUM_FIELDS];
    imu_read_t    rd;
    int           k;
    logic         in_fire;
    logic         out_fire;
    in_fire  = rst_n && in_bus.valid && in_bus.ready;
    out_fire = rst_n && out_bus.valid && out_bus.ready;
    in_taken <= in_fire;

    if (out_fire) begin
      got[0]  = out_bus.accel_x_scaled;
      got[1]  = out_bus.accel_y_scaled;
      got[2]  = out_bus.accel_z_scaled;
      got[3]  = out_bus.rate_x_scaled;
      got[4]  = out_bus.rate_y_scaled;
      got[5]  = out_bus.rate_z_scaled;
      got[6]  = out_bus.accel_x_smoothed;
      got[7]  = out_bus.accel_y_smoothed;
      got[8]  = out_bus.accel_z_smoothed;
      got[9]  = out_bus.rate_x_smoothed;
      got[10] = out_bus.rate_y_smoothed;
      got[11] = out_bus.rate_z_smoothed;
      if (awaited_outputs.size() == 0) begin
        $display("%0t output transfer with nothing due", $time);
        mismatch_count++;
      end else begin
        want = awaited_outputs.pop_front();
        for (k = 0; k < NUM_FIELDS; k++) begin
          if (got[k] !== want.vals[k]) begin
            $display("%0t mismatch %s: expected %0d, got %0d",
                     $time, field_name[k], want.vals[k], got[k]);
            mismatch_count++;
          end
        end
      end
    end

    // output is checked before the new expectation is queued
    if (in_fire) begin
      rd.accel[0] = in_bus.accel_x_word;
      rd.accel[1] = in_bus.accel_y_word;
      rd.accel[2] = in_bus.accel_z_word;
      rd.id       = in_bus.gyro_id_byte;
      rd.gyro[0]  = in_bus.gyro_x_word;
      rd.gyro[1]  = in_bus.gyro_y_word;
      rd.gyro[2]  = in_bus.gyro_z_word;
      awaited_outputs.push_back(scale_and_smooth(rd));
    end

    if (in_fire || out_fire) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int seg;
    int k;
    logic [CFG_DW-1:0] wval;

    rst_n   = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    in_bus.valid        = 1'b0;
    in_bus.accel_x_word = '0;
    in_bus.accel_y_word = '0;
    in_bus.accel_z_word = '0;
    in_bus.gyro_id_byte = '0;
    in_bus.gyro_x_word  = '0;
    in_bus.gyro_y_word  = '0;
    in_bus.gyro_z_word  = '0;
    out_bus.ready       = 1'b0;
    sender_idle_pct   = 18;
    receiver_idle_pct = 61;
    holds_asked       = 0;
    holds_served      = 0;
    hold_left         = 0;
    in_taken          = 1'b0;
    quiet_cycles      = 0;
    mismatch_count    = 0;
    filt_weight       = WEIGHT_RESET;
    filt_seeded       = 1'b0;
    for (k = 0; k < 3; k++) held_gyro[k] = '0;
    for (k = 0; k < 6; k++) filt_state[k] = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part at the reset weight
    // bad identity before any good gyro read: rates stay zero, filter seeds
    add_reading(16'h0000, 16'h0000, 16'h0000, 8'h00, 16'h7FFF, 16'h8000, 16'hFFFF);
    add_reading(16'h7FFF, 16'h8000, 16'hFFFF, 8'hFF, 16'h1234, 16'h5678, 16'h9ABC);
    // words with only the low byte or only the high byte set, good identity
    add_reading(16'h0001, 16'h00FF, 16'hFF00, GYRO_ID_OK, 16'h7FFF, 16'h8000, 16'hFFFF);
    // wrong identities keep the held gyro words
    add_reading(16'h8000, 16'h7FFF, 16'h0001, 8'h0E, 16'h0000, 16'h0000, 16'h0000);
    add_reading(16'hFFFF, 16'h0000, 16'h8000, 8'h1F, 16'h0001, 16'h0001, 16'h0001);
    add_reading(16'h00FF, 16'hFF00, 16'h7FFF, 8'hF0, 16'h8000, 16'h8000, 16'h8000);
    add_reading(16'h1234, 16'hEDCB, 16'h0100, 8'h8F, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_reading(16'h0000, 16'hFFFF, 16'h0001, GYRO_ID_OK, 16'h0000, 16'h0001, 16'h00FF);
    // full-scale steps through the filter
    add_reading(16'h7FFF, 16'h7FFF, 16'h7FFF, GYRO_ID_OK, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    add_reading(16'h8000, 16'h8000, 16'h8000, GYRO_ID_OK, 16'h8000, 16'h8000, 16'h8000);
    add_reading(16'hFFFF, 16'h0001, 16'h0000, GYRO_ID_OK, 16'hFF00, 16'h00FF, 16'hFFFF);
    wait_idle();

    // zero weight: smoothed values frozen
    write_reg(ADDR_SMOOTHING_WEIGHT, 32'd0);
    add_reading(16'h7FFF, 16'h8000, 16'h4000, GYRO_ID_OK, 16'h8000, 16'h7FFF, 16'hC000);
    add_reading(16'h8000, 16'h7FFF, 16'hC000, 8'h00, 16'h0000, 16'h0000, 16'h0000);
    wait_idle();

    // unity weight with junk in the upper data bits: no smoothing
    write_reg(ADDR_SMOOTHING_WEIGHT, 32'hFFFE_0000 | 32'd65536);
    add_reading(16'h4000, 16'hC000, 16'h0001, GYRO_ID_OK, 16'h0001, 16'hFFFF, 16'h7FFF);
    add_reading(16'hC000, 16'h4000, 16'hFFFF, GYRO_ID_OK, 16'h7FFF, 16'h8000, 16'h0001);
    wait_idle();

    // write to an address with no register: weight must stay at unity
    write_reg(ADDR_SPARE, 32'h0000_0001);
    add_reading(16'h7FFF, 16'h0000, 16'h8000, GYRO_ID_OK, 16'h8000, 16'h0000, 16'h7FFF);
    add_reading(16'h8000, 16'hFFFF, 16'h7FFF, GYRO_ID_OK, 16'h7FFF, 16'hFFFF, 16'h8000);
    wait_idle();

    // weight above one: clamped to no smoothing
    write_reg(ADDR_SMOOTHING_WEIGHT, 32'h0001_FFFF);
    add_reading(16'h0123, 16'hFEDC, 16'h8001, GYRO_ID_OK, 16'h1111, 16'hEEEE, 16'h7FFE);
    add_reading(16'h7FFE, 16'h8001, 16'h0123, 8'h0D, 16'h0000, 16'h0000, 16'h0000);
    wait_idle();

    // random part: segments with their own weight and idling profile
    for (seg = 0; seg < SEGMENTS; seg++) begin
      wait_idle();
      if (seg < 4) begin
        sender_idle_pct   = 18;
        receiver_idle_pct = 61;
      end else if (seg < 8) begin
        sender_idle_pct   = 61;
        receiver_idle_pct = 18;
      end else begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
      end
      case (seg % 6)
        0: wval = $urandom_range(65535, 1);
        1: wval = 32'd65536;
        2: wval = 32'd1;
        3: wval = 32'h0001_FFFF;
        4: wval = 32'd65535;
        default: wval = $urandom_range(2048, 0);
      endcase
      write_reg(ADDR_SMOOTHING_WEIGHT, wval);
      for (k = 0; k < SEG_READS; k++) begin
        add_reading(random_word(), random_word(), random_word(), random_id(),
                    random_word(), random_word(), random_word());
      end
      // long receiver hold-off while the sender keeps offering reads
      if (seg == 2 || seg == 9) holds_asked++;
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
